FILE: rtl/tdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division primality package
// Shared state encoding, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// width and ceiling of the trial division count
	localparam int unsigned COUNT_W = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_BOUND,
		S_DIV,
		S_TEST,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture the input beat
		logic init_k;     // first odd divisor: k = 3, k*k = 9
		logic count_inc;  // one more trial division
		logic start_div;  // clear remainder, reload the dividend shifter
		logic div_step;   // one restoring remainder step
		logic advance;    // k += 2, k*k updated incrementally
		logic set_prime;  // verdict: prime
		logic out_load;   // move verdict and count into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic n_small;    // number below two
		logic n_two;      // number equals two
		logic n_even;     // number is even
		logic sq_gt_n;    // k*k exceeds number
		logic div_last;   // final remainder step in progress
		logic rem_zero;   // remainder of number by k is zero
	} sts_t;

endpackage

FILE: rtl/tdp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division primality controller
// Sequences classification, bound check, remainder and output hand-off.
// ----------------------------------------------------------------------------
module tdp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tdp_pkg::sts_t sts,
	output tdp_pkg::cmd_t cmd
);

	tdp_pkg::state_t state_q;
	tdp_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	// output register can take a new beat
	assign out_free = !out_valid_q || !out_stall;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tdp_pkg::S_IDLE: begin
				if (in_valid) state_nxt = tdp_pkg::S_CLASS;
			end
			tdp_pkg::S_CLASS: begin
				if (sts.n_small || sts.n_two || sts.n_even) begin
					state_nxt = tdp_pkg::S_DONE;
				end else begin
					state_nxt = tdp_pkg::S_BOUND;
				end
			end
			tdp_pkg::S_BOUND: begin
				if (sts.sq_gt_n) begin
					state_nxt = tdp_pkg::S_DONE;
				end else begin
					state_nxt = tdp_pkg::S_DIV;
				end
			end
			tdp_pkg::S_DIV: begin
				if (sts.div_last) state_nxt = tdp_pkg::S_TEST;
			end
			tdp_pkg::S_TEST: begin
				if (sts.rem_zero) begin
					state_nxt = tdp_pkg::S_DONE;
				end else begin
					state_nxt = tdp_pkg::S_BOUND;
				end
			end
			tdp_pkg::S_DONE: begin
				if (out_free) state_nxt = tdp_pkg::S_IDLE;
			end
			default: state_nxt = tdp_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tdp_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			tdp_pkg::S_CLASS: begin
				if (sts.n_small) begin
					cmd.set_prime = 1'b0;
				end else if (sts.n_two) begin
					cmd.set_prime = 1'b1;
				end else if (!sts.n_even) begin
					cmd.init_k = 1'b1;
				end
			end
			tdp_pkg::S_BOUND: begin
				if (sts.sq_gt_n) begin
					cmd.set_prime = 1'b1;
				end else begin
					cmd.count_inc = 1'b1;
					cmd.start_div = 1'b1;
				end
			end
			tdp_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			tdp_pkg::S_TEST: begin
				if (!sts.rem_zero) cmd.advance = 1'b1;
			end
			tdp_pkg::S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/tdp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division primality datapath
// Holds the operand, odd divisor and its square, a bit-serial remainder
// unit, the saturating count and the output register.
// ----------------------------------------------------------------------------
module tdp_dp #(
	parameter int unsigned NUMBER_WIDTH = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NUMBER_WIDTH-1:0]       number,
	input  tdp_pkg::cmd_t                 cmd,
	output tdp_pkg::sts_t                 sts,
	output logic                          is_prime,
	output logic [tdp_pkg::COUNT_W-1:0]   modulo_count
);

	localparam int unsigned NW = NUMBER_WIDTH;
	localparam int unsigned KW = NW / 2 + 2;        // divisor width, k <= sqrt(n) + 2
	localparam int unsigned SW = NW + 1;            // square width
	localparam int unsigned CW = $clog2(NW);        // remainder step counter

	logic [NW-1:0]               n_q;
	logic [NW-1:0]               shift_q;
	logic [KW-1:0]               k_q;
	logic [SW-1:0]               sq_q;
	logic [KW-1:0]               rem_q;
	logic [CW-1:0]               step_q;
	logic [tdp_pkg::COUNT_W-1:0] count_q;
	logic                        prime_q;
	logic                        is_prime_q;
	logic [tdp_pkg::COUNT_W-1:0] modulo_count_q;

	logic [KW:0]                 trial;
	logic [KW:0]                 trial_diff;
	logic                        trial_ge;

	// one restoring step: bring down the next dividend bit
	assign trial      = {rem_q, shift_q[NW-1]};
	assign trial_diff = trial - {1'b0, k_q};
	assign trial_ge   = trial >= {1'b0, k_q};

	// operand, divisor and square
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= number;
		end
		if (cmd.init_k) begin
			k_q  <= KW'(3);
			sq_q <= SW'(9);
		end else if (cmd.advance) begin
			// (k+2)^2 = k^2 + 4k + 4
			k_q  <= k_q + KW'(2);
			sq_q <= sq_q + SW'({k_q, 2'b00}) + SW'(4);
		end
	end

	// bit-serial remainder unit
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q   <= '0;
			shift_q <= n_q;
			step_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= trial_ge ? trial_diff[KW-1:0] : trial[KW-1:0];
			shift_q <= {shift_q[NW-2:0], 1'b0};
			step_q  <= step_q + CW'(1);
		end
	end

	// verdict and saturating count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prime_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
				prime_q <= 1'b0;
			end else begin
				if (cmd.count_inc && count_q != tdp_pkg::COUNT_MAX) begin
					count_q <= count_q + tdp_pkg::COUNT_W'(1);
				end
				if (cmd.set_prime) begin
					prime_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			is_prime_q     <= prime_q;
			modulo_count_q <= count_q;
		end
	end

	// status
	assign sts.n_small  = n_q < NW'(2);
	assign sts.n_two    = n_q == NW'(2);
	assign sts.n_even   = !n_q[0];
	assign sts.sq_gt_n  = sq_q > {1'b0, n_q};
	assign sts.div_last = step_q == CW'(NW - 1);
	assign sts.rem_zero = rem_q == '0;

	assign is_prime     = is_prime_q;
	assign modulo_count = modulo_count_q;

endmodule

FILE: rtl/trial_division_primality_top.sv
`timescale 1ns / 1ps
// Numbers 0, 1, 2 and even numbers are settled by classification alone; a prime below nine
//   takes no trial division, and the search stops at the first exact division.
// Each trial division is one bound check, NUMBER_WIDTH remainder steps and one test.
// One number in flight; the next is taken the cycle after the result enters the output register.
// Reset clears the controller and the output valid; no result is pending after reset.
// ----------------------------------------------------------------------------
// Trial division primality test
// Reports whether a number is prime and how many odd trial divisions it took.
// ----------------------------------------------------------------------------
module trial_division_primality_top #(
	parameter int unsigned NUMBER_WIDTH = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [NUMBER_WIDTH-1:0]     number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_prime,
	output logic [tdp_pkg::COUNT_W-1:0] modulo_count
);

	tdp_pkg::cmd_t cmd;
	tdp_pkg::sts_t sts;

	// sequencer
	tdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// operand, divisor and remainder datapath
	tdp_dp #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.number       (number),
		.cmd          (cmd),
		.sts          (sts),
		.is_prime     (is_prime),
		.modulo_count (modulo_count)
	);

endmodule

FILE: verif/trial_division_primality_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division primality checker
// Watches both channels of the primality block. Each accepted number is run
// through an independent trial-division predictor. Each accepted result is
// compared field by field against the oldest pending verdict.
// ----------------------------------------------------------------------------
module trial_division_primality_checker #(
	parameter int unsigned NUMBER_WIDTH = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [NUMBER_WIDTH-1:0]     number,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        is_prime,
	input  logic [tdp_pkg::COUNT_W-1:0] modulo_count,
	output int                          fails,
	output int                          pending,
	output int                          checked,
	output int                          primes,
	output int                          deepest
);

	// verdict predicted for one number
	typedef struct packed {
		logic [NUMBER_WIDTH-1:0]     number;
		logic                        prime;
		logic [tdp_pkg::COUNT_W-1:0] count;
	} verdict_t;

	verdict_t verdict_q[$];
	verdict_t head;

	// odd divisors from 3 while k*k <= n, stop at the first exact one
	function automatic verdict_t trial_divide(input logic [NUMBER_WIDTH-1:0] n);
		verdict_t        v;
		longint unsigned value;
		longint unsigned k;
		int unsigned     divisions;
		logic            found;
		value     = n;
		divisions = 0;
		found     = 1'b0;
		v.number  = n;
		if (value < 2) begin
			v.prime = 1'b0;
		end else if (value == 2) begin
			v.prime = 1'b1;
		end else if (n[0] == 1'b0) begin
			v.prime = 1'b0;
		end else begin
			k = 3;
			// k <= n / k keeps the bound free of overflow
			while (!found && k <= value / k) begin
				if (divisions < tdp_pkg::COUNT_MAX)
					divisions++;
				if (value % k == 0)
					found = 1'b1;
				else
					k += 2;
			end
			v.prime = !found;
		end
		v.count = divisions[tdp_pkg::COUNT_W-1:0];
		return v;
	endfunction

	// one line per mismatch
	task automatic report(input string field, input longint unsigned num,
			input longint unsigned want, input longint unsigned got);
		$display("[%0t] mismatch on %s for number %0d: expected %0d, got %0d",
			$time, field, num, want, got);
		fails++;
	endtask

	// retire results before taking new numbers
	always @(posedge clk) begin
		if (!arst_n) begin
			fails   = 0;
			checked = 0;
			primes  = 0;
			deepest = 0;
			verdict_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report("result with nothing pending", 0, 0, {is_prime, modulo_count});
				end else begin
					head = verdict_q.pop_front();
					checked++;
					if (is_prime !== head.prime)
						report("is_prime", head.number, head.prime, is_prime);
					if (modulo_count !== head.count)
						report("modulo_count", head.number, head.count, modulo_count);
					if (head.prime)
						primes++;
					if (int'(head.count) > deepest)
						deepest = int'(head.count);
				end
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(trial_divide(number));
			pending <= verdict_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division primality testbench
// Drives corner numbers and a random mix of cheap-to-test numbers into the
// block with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned NUMBER_WIDTH = 31;
	localparam int          RANDOM_BEATS = 78;
	localparam int          DRAIN_CYCLES = 60;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [NUMBER_WIDTH-1:0]     number;
	logic                        out_valid;
	logic                        out_stall;
	logic                        is_prime;
	logic [tdp_pkg::COUNT_W-1:0] modulo_count;

	int   fails;
	int   pending;
	int   checked;
	int   primes;
	int   deepest;
	int   sent;
	int   stall_left;
	logic calm;

	// corner numbers: trivial cases, squares of small primes, widest values
	longint unsigned corner_numbers[22] = '{
		0, 1, 2, 3, 4, 5, 7, 8, 9, 15, 25, 49, 97, 121, 169, 10007,
		1073741824, 715827882, 1431655765, 2147483645, 2147483646, 2147483647
	};

	trial_division_primality_top #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.number       (number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_prime     (is_prime),
		.modulo_count (modulo_count)
	);

	trial_division_primality_checker #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.number       (number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_prime     (is_prime),
		.modulo_count (modulo_count),
		.fails        (fails),
		.pending      (pending),
		.checked      (checked),
		.primes       (primes),
		.deepest      (deepest)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 40);
	endfunction

	// random number whose search stays short
	function automatic logic [NUMBER_WIDTH-1:0] pick_number();
		int unsigned             roll;
		longint unsigned         p;
		longint unsigned         q;
		logic [NUMBER_WIDTH-1:0] n;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			// full-width even value
			n    = NUMBER_WIDTH'($urandom);
			n[0] = 1'b0;
		end else if (roll < 55) begin
			// full-width odd multiple of a small odd factor
			case ($urandom_range(0, 4))
				0: p = 3;
				1: p = 5;
				2: p = 7;
				3: p = 11;
				default: p = 13;
			endcase
			q = $urandom_range(0, (2147483647 / p - 1) / 2);
			n = NUMBER_WIDTH'((2 * q + 1) * p);
		end else if (roll < 80) begin
			n = NUMBER_WIDTH'($urandom_range(0, 4095));
		end else begin
			n = NUMBER_WIDTH'($urandom_range(4096, 65535) | 1);
		end
		return n;
	endfunction

	// offer one beat and hold it until taken, then maybe idle
	task automatic feed_number(input logic [NUMBER_WIDTH-1:0] n);
		int gap;
		in_valid <= 1'b1;
		number   <= n;
		do @(posedge clk); while (in_stall);
		sent++;
		gap = calm ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			number   <= NUMBER_WIDTH'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver stalls in random runs, with out_stall always released between runs
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall  <= 1'b0;
				stall_left = calm ? 0 : gap_len();
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		number   = '0;
		calm     = 1'b0;
		sent     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_numbers[i])
			feed_number(corner_numbers[i][NUMBER_WIDTH-1:0]);

		// hold off until the block has answered everything
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			calm = (i >= 40 && i < 60);
			feed_number(pick_number());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d numbers: corners, full-width even and small-factor odd values,",
			sent);
		$display("small and mid-size values; %0d results checked, %0d prime, deepest search %0d",
			checked, primes, deepest);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("timeout with %0d results pending", pending);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: trial_division_primality_top.f
rtl/tdp_pkg.sv
rtl/tdp_ctrl.sv
rtl/tdp_dp.sv
rtl/trial_division_primality_top.sv
verif/trial_division_primality_checker.sv
verif/testbench.sv
